[design/lcs_pkg.sv]
// Shared types and constants for the line column span block.
package lcs_pkg;

    // Result row fields are 14-bit two's complement
    localparam int ROW_BITS   = 14;
    localparam int COLOR_BITS = 8;
    localparam int CNT_BITS   = 7;

    typedef logic signed [ROW_BITS-1:0] row_t;
    typedef logic [COLOR_BITS-1:0]      color_t;
    typedef logic [CNT_BITS-1:0]        cnt_t;

    // Thick width register after reset
    localparam cnt_t THICK_RESET = 7'd10;

    // Saturation limits of the row fields
    localparam row_t ROW_MIN = 14'sh2000;
    localparam row_t ROW_MAX = 14'sh1FFF;

    // Line mode carried on s_tuser
    localparam logic MODE_THIN  = 1'b0;
    localparam logic MODE_THICK = 1'b1;

    // Result word: row_low, row_high, red, green, blue, zero pad to bytes
    localparam int M_FIELD_W = 2 * ROW_BITS + 3 * COLOR_BITS;
    localparam int M_DATA_W  = ((M_FIELD_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_DATA_W - M_FIELD_W;

endpackage

[design/lcs_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage, with side payload.
module lcs_div_pipe #(
    parameter int COORD_BITS = 12,
    parameter int SIDE_W     = 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [SIDE_W-1:0]       in_side,
    input  logic [COORD_BITS-1:0]   in_den,
    input  logic [2*COORD_BITS-1:0] in_work,   // dividend, upper half below in_den
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [SIDE_W-1:0]       out_side,
    output logic [COORD_BITS-1:0]   out_quot
);

    localparam int CB = COORD_BITS;

    logic                valid_reg [CB];
    logic [SIDE_W-1:0]   side_reg  [CB];
    logic [CB-1:0]       den_reg   [CB];
    logic [2*CB-1:0]     work_reg  [CB];
    logic [2*CB-1:0]     work_next [CB];
    logic                stage_ready [CB+1];

    // One restoring step: shift in the next dividend bit, subtract if it fits
    function automatic logic [2*CB-1:0] div_step(input logic [2*CB-1:0] w,
                                                input logic [CB-1:0] d);
        logic [CB:0]   trial;
        logic [CB:0]   diff;
        logic          fits;
        logic [CB-1:0] rem;
        trial = {w[2*CB-1:CB], w[CB-1]};
        diff  = trial - {1'b0, d};
        fits  = (trial >= {1'b0, d});
        rem   = fits ? diff[CB-1:0] : trial[CB-1:0];
        return {rem, w[CB-2:0], fits};
    endfunction

    assign stage_ready[CB] = out_ready;
    assign in_ready        = stage_ready[0];

    for (genvar i = 0; i < CB; i++) begin : g_stage
        logic              valid_prev;
        logic [SIDE_W-1:0] side_prev;
        logic [CB-1:0]     den_prev;
        logic [2*CB-1:0]   work_prev;

        if (i == 0) begin : g_first
            assign valid_prev = in_valid;
            assign side_prev  = in_side;
            assign den_prev   = in_den;
            assign work_prev  = in_work;
        end else begin : g_next
            assign valid_prev = valid_reg[i-1];
            assign side_prev  = side_reg[i-1];
            assign den_prev   = den_reg[i-1];
            assign work_prev  = work_reg[i-1];
        end

        // Stage takes a word when empty or when its own word moves on
        assign stage_ready[i] = !valid_reg[i] || stage_ready[i+1];

        always_comb begin
            work_next[i] = div_step(work_prev, den_prev);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (stage_ready[i]) begin
                valid_reg[i] <= valid_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_ready[i] && valid_prev) begin
                side_reg[i] <= side_prev;
                den_reg[i]  <= den_prev;
                work_reg[i] <= work_next[i];
            end
        end
    end

    assign out_valid = valid_reg[CB-1];
    assign out_side  = side_reg[CB-1];
    assign out_quot  = work_reg[CB-1][CB-1:0];

endmodule

[design/line_column_span.sv]
// Top level: column query of a line segment, returning the row span drawn there.
//
//   channel | ports                        | word
//   --------+------------------------------+-----------------------------------------
//   input   | s_tvalid s_tready s_tdata    | segment ends, column, color; s_tuser=mode
//   result  | m_tvalid m_tready m_tdata    | row span and color; m_tuser=draw
//   config  | cfg_valid cfg_ready cfg_data | thick_count, always ready
//
// Stages: classify, multiply, one divider stage per quotient bit, then span
// add and saturation into the output register. One word enters per cycle
// unless a stall at m_tready has filled the stages.
// Reset clears all valid bits and sets thick_count to 10.
// A stall at m_tready fills empty stages first; no word is dropped or repeated.
module line_column_span #(
    parameter int  COORD_BITS = 12,
    localparam int S_FIELD_W  = 5 * COORD_BITS + 3 * lcs_pkg::COLOR_BITS,
    localparam int S_DATA_W   = ((S_FIELD_W + 7) / 8) * 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // start_x, start_y, end_x, end_y, column, red_in, green_in, blue_in
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [S_DATA_W-1:0]          s_tdata,
    // mode
    input  logic                         s_tuser,
    // row_low, row_high, red_out, green_out, blue_out
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [lcs_pkg::M_DATA_W-1:0] m_tdata,
    // draw
    output logic                         m_tuser,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [lcs_pkg::CNT_BITS-1:0] cfg_data
);

    localparam int CB     = COORD_BITS;
    localparam int CNTW   = lcs_pkg::CNT_BITS;
    localparam int COLW   = lcs_pkg::COLOR_BITS;
    localparam int ROWW   = lcs_pkg::ROW_BITS;
    localparam int BASE_W = CB + 2;
    localparam int SUM_W  = CB + 3;
    localparam int WIDE_W = ((SUM_W > ROWW) ? SUM_W : ROWW) + 1;

    typedef struct packed {
        logic                     draw;
        logic                     sloped;
        logic                     neg;
        logic signed [BASE_W-1:0] lo_base;
        logic signed [BASE_W-1:0] hi_base;
        lcs_pkg::color_t          red;
        lcs_pkg::color_t          green;
        lcs_pkg::color_t          blue;
    } ctl_t;

    localparam int SIDE_W = $bits(ctl_t);

    // Configuration register
    lcs_pkg::cnt_t thick_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thick_count_reg <= lcs_pkg::THICK_RESET;
        end else if (cfg_valid) begin
            thick_count_reg <= cfg_data;
        end
    end

    // Unpack the input word
    logic [CB-1:0]   x0, y0, x1, y1, col;
    lcs_pkg::color_t red_in, green_in, blue_in;

    assign x0       = s_tdata[CB-1:0];
    assign y0       = s_tdata[2*CB-1:CB];
    assign x1       = s_tdata[3*CB-1:2*CB];
    assign y1       = s_tdata[4*CB-1:3*CB];
    assign col      = s_tdata[5*CB-1:4*CB];
    assign red_in   = s_tdata[5*CB+COLW-1:5*CB];
    assign green_in = s_tdata[5*CB+2*COLW-1:5*CB+COLW];
    assign blue_in  = s_tdata[5*CB+3*COLW-1:5*CB+2*COLW];

    // Classify the segment and build span bases
    logic                     thick, vertical, horiz, in_range, v_cols, cnt_zero;
    logic [CB:0]              cnt_ext;
    lcs_pkg::cnt_t            reach;
    logic signed [BASE_W-1:0] y0_s, y1_s, reach_s;
    ctl_t                     a_ctl_next;
    logic [CB-1:0]            a_dymag_next, a_dxc_next, a_den_next;

    always_comb begin
        thick    = (s_tuser == lcs_pkg::MODE_THICK);
        vertical = (x1 == x0);
        horiz    = (y1 == y0);
        in_range = (col >= x0) && (col < x1);
        cnt_zero = (thick_count_reg == '0);
        cnt_ext  = {{(CB + 1 - CNTW){1'b0}}, thick_count_reg};
        v_cols   = thick ? ((col >= x1) && ({1'b0, col} < ({1'b0, x1} + cnt_ext)))
                         : (col == x1);
        reach    = thick ? (thick_count_reg - CNTW'(1)) : CNTW'(1);
        y0_s     = signed'({2'b00, y0});
        y1_s     = signed'({2'b00, y1});
        reach_s  = signed'({{(BASE_W - CNTW){1'b0}}, reach});

        a_ctl_next.draw   = vertical ? (v_cols && (y0 < y1))
                                     : (in_range && (horiz || !thick || !cnt_zero));
        a_ctl_next.sloped = !vertical && !horiz;
        a_ctl_next.neg    = (y1 < y0);
        if (vertical) begin
            a_ctl_next.lo_base = y0_s;
            a_ctl_next.hi_base = y1_s - BASE_W'(1);
        end else if (horiz) begin
            a_ctl_next.lo_base = y0_s;
            a_ctl_next.hi_base = y0_s;
        end else begin
            a_ctl_next.lo_base = y0_s - reach_s;
            a_ctl_next.hi_base = y0_s + reach_s;
        end
        a_ctl_next.red   = red_in;
        a_ctl_next.green = green_in;
        a_ctl_next.blue  = blue_in;

        a_dymag_next = (y1 < y0) ? (y0 - y1) : (y1 - y0);
        a_dxc_next   = col - x0;
        a_den_next   = x1 - x0;
    end

    // Stage handshake chain
    logic a_valid_reg, b_valid_reg, m_valid_reg;
    logic a_ready, b_ready, z_ready;
    logic div_in_ready, div_out_valid;

    assign z_ready  = !m_valid_reg || m_tready;
    assign b_ready  = !b_valid_reg || div_in_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign s_tready = a_ready;

    // Stage A: classified word
    ctl_t          a_ctl_reg;
    logic [CB-1:0] a_dymag_reg, a_dxc_reg, a_den_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && s_tvalid) begin
            a_ctl_reg   <= a_ctl_next;
            a_dymag_reg <= a_dymag_next;
            a_dxc_reg   <= a_dxc_next;
            a_den_reg   <= a_den_next;
        end
    end

    // Stage B: product |dy| * (column - start_x)
    ctl_t            b_ctl_reg;
    logic [CB-1:0]   b_den_reg;
    logic [2*CB-1:0] b_prod_reg;
    logic [2*CB-1:0] b_prod_next;

    assign b_prod_next = a_dymag_reg * a_dxc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_ready && a_valid_reg) begin
            b_ctl_reg  <= a_ctl_reg;
            b_den_reg  <= a_den_reg;
            b_prod_reg <= b_prod_next;
        end
    end

    // Divide the product by the segment width
    logic [SIDE_W-1:0] div_side;
    logic [CB-1:0]     div_quot;
    ctl_t              z_ctl;

    lcs_div_pipe #(
        .COORD_BITS (COORD_BITS),
        .SIDE_W     (SIDE_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (b_valid_reg),
        .in_ready  (div_in_ready),
        .in_side   (b_ctl_reg),
        .in_den    (b_den_reg),
        .in_work   (b_prod_reg),
        .out_valid (div_out_valid),
        .out_ready (z_ready),
        .out_side  (div_side),
        .out_quot  (div_quot)
    );

    assign z_ctl = ctl_t'(div_side);

    // Clamp a span sum to the row field range
    function automatic lcs_pkg::row_t sat_row(input logic signed [SUM_W-1:0] s);
        logic [WIDE_W-1:0]      wide;
        logic [WIDE_W-ROWW:0]   upper;
        wide  = {{(WIDE_W - SUM_W){s[SUM_W-1]}}, s};
        upper = wide[WIDE_W-1:ROWW-1];
        if ((upper == '0) || (upper == '1)) begin
            return lcs_pkg::row_t'(wide[ROWW-1:0]);
        end else if (wide[WIDE_W-1]) begin
            return lcs_pkg::ROW_MIN;
        end else begin
            return lcs_pkg::ROW_MAX;
        end
    endfunction

    // Final stage: apply signed quotient, saturate, zero when not drawn
    logic signed [CB:0]    q_ext, sq;
    logic signed [SUM_W-1:0] lo_sum, hi_sum;
    lcs_pkg::row_t         row_low_next, row_high_next;

    always_comb begin
        q_ext  = signed'({1'b0, div_quot});
        sq     = z_ctl.sloped ? (z_ctl.neg ? -q_ext : q_ext) : '0;
        lo_sum = {z_ctl.lo_base[BASE_W-1], z_ctl.lo_base}
               + {{2{sq[CB]}}, sq};
        hi_sum = {z_ctl.hi_base[BASE_W-1], z_ctl.hi_base}
               + {{2{sq[CB]}}, sq};
        row_low_next  = z_ctl.draw ? sat_row(lo_sum) : '0;
        row_high_next = z_ctl.draw ? sat_row(hi_sum) : '0;
    end

    // Output register
    logic            m_draw_reg;
    lcs_pkg::row_t   m_low_reg, m_high_reg;
    lcs_pkg::color_t m_red_reg, m_green_reg, m_blue_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (z_ready) begin
            m_valid_reg <= div_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (z_ready && div_out_valid) begin
            m_draw_reg  <= z_ctl.draw;
            m_low_reg   <= row_low_next;
            m_high_reg  <= row_high_next;
            m_red_reg   <= z_ctl.red;
            m_green_reg <= z_ctl.green;
            m_blue_reg  <= z_ctl.blue;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_draw_reg;
    assign m_tdata  = {{lcs_pkg::M_PAD_W{1'b0}}, m_blue_reg, m_green_reg, m_red_reg,
                       m_high_reg, m_low_reg};

endmodule

[design/lcs_checker.sv]
// Port-level checks for the line column span block, bound to its top level.
module lcs_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [lcs_pkg::M_DATA_W-1:0] m_tdata,
    input logic                         m_tuser
);

    localparam int ROWW = lcs_pkg::ROW_BITS;

    logic signed [ROWW-1:0] row_low, row_high;

    assign row_low  = m_tdata[ROWW-1:0];
    assign row_high = m_tdata[2*ROWW-1:ROWW];

    // Pipeline is empty right after a reset cycle
    a_empty_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

    // An undrawn column carries zero rows
    a_undrawn_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> ((row_low == '0) && (row_high == '0)))
        else $error("undrawn result has nonzero rows");

    // A drawn span is never reversed
    a_span_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (row_low <= row_high))
        else $error("drawn span has row_low above row_high");

    // A stalled result word holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result word changed");

endmodule

bind line_column_span lcs_checker u_lcs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[test/tb.sv]
// Self-checking testbench for the line column span block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS     = 12;
    localparam int S_DATA_W       = ((5 * COORD_BITS + 3 * lcs_pkg::COLOR_BITS + 7) / 8) * 8;
    localparam int COORD_MAX      = (1 << COORD_BITS) - 1;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT     = 5000;
    localparam int DRAIN_CYCLES   = COORD_BITS + 8;
    localparam int ROWB           = lcs_pkg::ROW_BITS;
    localparam int COLB           = lcs_pkg::COLOR_BITS;

    typedef struct {
        logic                  mode;
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS-1:0] start_y;
        logic [COORD_BITS-1:0] end_x;
        logic [COORD_BITS-1:0] end_y;
        logic [COORD_BITS-1:0] column;
        lcs_pkg::color_t       red_in;
        lcs_pkg::color_t       green_in;
        lcs_pkg::color_t       blue_in;
    } seg_query_t;

    typedef struct {
        logic            draw;
        lcs_pkg::row_t   row_low;
        lcs_pkg::row_t   row_high;
        lcs_pkg::color_t red;
        lcs_pkg::color_t green;
        lcs_pkg::color_t blue;
    } span_t;

    logic                         aclk      = 1'b0;
    logic                         aresetn   = 1'b0;
    logic                         s_tvalid  = 1'b0;
    logic                         s_tready;
    logic [S_DATA_W-1:0]          s_tdata   = '0;
    logic                         s_tuser   = lcs_pkg::MODE_THIN;
    logic                         m_tvalid;
    logic                         m_tready  = 1'b0;
    logic [lcs_pkg::M_DATA_W-1:0] m_tdata;
    logic                         m_tuser;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    lcs_pkg::cnt_t                cfg_data  = '0;

    // Receiver controls, written with nonblocking assignments
    logic                  rx_burst  = 1'b0;
    logic                  hold_off  = 1'b0;
    event                  rx_hold_go;

    bit                    tx_burst;
    lcs_pkg::cnt_t         thick_now = lcs_pkg::THICK_RESET;
    span_t                 span_queue[$];
    int                    mismatches;
    int                    results_seen;
    int                    idle_cycles;

    line_column_span #(
        .COORD_BITS(COORD_BITS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Clamp a row to the 14-bit signed field
    function automatic lcs_pkg::row_t sat_row(input int r);
        if (r < int'(lcs_pkg::ROW_MIN)) return lcs_pkg::ROW_MIN;
        if (r > int'(lcs_pkg::ROW_MAX)) return lcs_pkg::ROW_MAX;
        return lcs_pkg::row_t'(r);
    endfunction

    // Row span of one segment in the queried column
    function automatic span_t column_span(input seg_query_t q, input lcs_pkg::cnt_t cnt);
        span_t s;
        int    x0, y0, x1, y1, col, n, c, lo, hi;
        bit    hit;
        bit    in_cols;
        x0  = int'(q.start_x);
        y0  = int'(q.start_y);
        x1  = int'(q.end_x);
        y1  = int'(q.end_y);
        col = int'(q.column);
        n   = int'(cnt);
        hit = 1'b0;
        lo  = 0;
        hi  = 0;
        if (x1 == x0) begin
            in_cols = (q.mode == lcs_pkg::MODE_THICK) ? (col >= x1 && col < x1 + n)
                                                      : (col == x1);
            if (in_cols && y0 < y1) begin
                hit = 1'b1;
                lo  = y0;
                hi  = y1 - 1;
            end
        end else if (col >= x0 && col < x1) begin
            if (y1 == y0) begin
                hit = 1'b1;
                lo  = y0;
                hi  = y0;
            end else begin
                // int division truncates toward zero
                c = (y1 - y0) * (col - x0) / (x1 - x0) + y0;
                if (q.mode == lcs_pkg::MODE_THIN) begin
                    hit = 1'b1;
                    lo  = c - 1;
                    hi  = c + 1;
                end else if (n > 0) begin
                    hit = 1'b1;
                    lo  = c - (n - 1);
                    hi  = c + (n - 1);
                end
            end
        end
        s.draw     = hit;
        s.row_low  = hit ? sat_row(lo) : '0;
        s.row_high = hit ? sat_row(hi) : '0;
        s.red      = q.red_in;
        s.green    = q.green_in;
        s.blue     = q.blue_in;
        return s;
    endfunction

    function automatic seg_query_t make_query(input logic m, input int sx, input int sy,
                                              input int ex, input int ey, input int col);
        seg_query_t q;
        q.mode     = m;
        q.start_x  = COORD_BITS'(sx);
        q.start_y  = COORD_BITS'(sy);
        q.end_x    = COORD_BITS'(ex);
        q.end_y    = COORD_BITS'(ey);
        q.column   = COORD_BITS'(col);
        q.red_in   = lcs_pkg::color_t'($urandom_range(0, 255));
        q.green_in = lcs_pkg::color_t'($urandom_range(0, 255));
        q.blue_in  = lcs_pkg::color_t'($urandom_range(0, 255));
        return q;
    endfunction

    // Mostly well-formed segments with the column near their range, some noise
    function automatic seg_query_t random_query();
        int sx, sy, ex, ey, col, kind, n, t;
        n    = int'(thick_now);
        kind = $urandom_range(0, 9);
        sx   = $urandom_range(0, COORD_MAX);
        sy   = $urandom_range(0, COORD_MAX);
        ex   = $urandom_range(0, COORD_MAX);
        ey   = $urandom_range(0, COORD_MAX);
        col  = $urandom_range(0, COORD_MAX);
        if (kind <= 2) begin
            // vertical
            ex = sx;
            if ($urandom_range(0, 7) != 0 && sy > ey) begin
                t  = sy;
                sy = ey;
                ey = t;
            end
            col = ex + int'($urandom_range(0, n + 1)) - (($urandom_range(0, 3) == 0) ? 1 : 0);
        end else if (kind <= 8) begin
            // horizontal or sloped, start column left of end column
            if (sx > ex) begin
                t  = sx;
                sx = ex;
                ex = t;
            end
            if (sx == ex) begin
                if (ex == COORD_MAX) sx = COORD_MAX - 1;
                else ex = sx + 1;
            end
            if ($urandom_range(0, 3) == 0) begin
                ex = sx + $urandom_range(1, 6);
                if (ex > COORD_MAX) ex = COORD_MAX;
            end
            if (kind <= 4) ey = sy;
            col = sx - 1 + int'($urandom_range(0, ex - sx + 1));
        end
        return make_query(1'($urandom_range(0, 1)), sx, sy, ex, ey, col);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at result %0d: %s", results_seen, msg);
        mismatches++;
    endtask

    // Offer one word after a random gap and record its expected span
    task automatic send_query(input seg_query_t q);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            if (s_tvalid) s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= q.mode;
        s_tdata  <= S_DATA_W'({q.blue_in, q.green_in, q.red_in, q.column,
                               q.end_y, q.end_x, q.start_y, q.start_x});
        do @(posedge aclk); while (!s_tready);
        span_queue.push_back(column_span(q, thick_now));
    endtask

    // Stop offering and hold until every expected span has arrived
    task automatic wait_results_done();
        if (s_tvalid) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        while (span_queue.size() != 0) @(posedge aclk);
    endtask

    task automatic write_thick(input lcs_pkg::cnt_t value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        thick_now = value;
        @(posedge aclk);
    endtask

    task automatic test_directed_cases();
        seg_query_t q;
        // vertical, thin and thick, inside and at the edges of the column range
        send_query(make_query(lcs_pkg::MODE_THIN,  100, 20, 100, 60, 100));
        send_query(make_query(lcs_pkg::MODE_THIN,  100, 20, 100, 60, 101));
        send_query(make_query(lcs_pkg::MODE_THIN,  100, 60, 100, 60, 100));
        send_query(make_query(lcs_pkg::MODE_THICK, 100, 20, 100, 60, 109));
        send_query(make_query(lcs_pkg::MODE_THICK, 100, 20, 100, 60, 110));
        send_query(make_query(lcs_pkg::MODE_THICK, 100, 20, 100, 60, 99));
        // horizontal, including the end column and a reversed segment
        send_query(make_query(lcs_pkg::MODE_THIN,  10, 300, 50, 300, 10));
        send_query(make_query(lcs_pkg::MODE_THIN,  10, 300, 50, 300, 50));
        send_query(make_query(lcs_pkg::MODE_THICK, 10, 300, 50, 300, 49));
        send_query(make_query(lcs_pkg::MODE_THIN,  50, 300, 10, 300, 20));
        // sloped, rising and falling; the falling one shows truncation toward zero
        send_query(make_query(lcs_pkg::MODE_THIN,  0, 0, 7, 10, 3));
        send_query(make_query(lcs_pkg::MODE_THIN,  0, 10, 7, 0, 3));
        send_query(make_query(lcs_pkg::MODE_THICK, 0, 10, 7, 0, 3));
        send_query(make_query(lcs_pkg::MODE_THIN,  5, 0, 9, 100, 5));
        // coordinate and color extremes
        q = make_query(lcs_pkg::MODE_THICK, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                       COORD_MAX);
        q.red_in   = '1;
        q.green_in = '1;
        q.blue_in  = '1;
        send_query(q);
        q = make_query(lcs_pkg::MODE_THIN, 0, 0, 0, 0, 0);
        q.red_in   = '0;
        q.green_in = '0;
        q.blue_in  = '0;
        send_query(q);
        send_query(make_query(lcs_pkg::MODE_THIN,  0, 0, COORD_MAX, COORD_MAX, COORD_MAX - 1));
        send_query(make_query(lcs_pkg::MODE_THICK, 0, COORD_MAX, COORD_MAX, 0, COORD_MAX - 1));
        send_query(make_query(lcs_pkg::MODE_THICK, COORD_MAX, 0, COORD_MAX, COORD_MAX,
                              COORD_MAX));
        // zero thick count: thick vertical and sloped draw nothing
        wait_results_done();
        write_thick('0);
        send_query(make_query(lcs_pkg::MODE_THICK, 100, 20, 100, 60, 100));
        send_query(make_query(lcs_pkg::MODE_THICK, 0, 0, 7, 10, 3));
        send_query(make_query(lcs_pkg::MODE_THIN,  0, 0, 7, 10, 3));
        send_query(make_query(lcs_pkg::MODE_THICK, 10, 300, 50, 300, 10));
        wait_results_done();
    endtask

    task automatic test_thick_sweep();
        lcs_pkg::cnt_t settings[5];
        settings = '{lcs_pkg::cnt_t'(1), lcs_pkg::cnt_t'(64), lcs_pkg::cnt_t'(127),
                     lcs_pkg::cnt_t'(0), lcs_pkg::cnt_t'($urandom_range(2, 63))};
        foreach (settings[i]) begin
            write_thick(settings[i]);
            repeat (30) send_query(random_query());
            wait_results_done();
        end
    endtask

    // Hold the receiver off while the sender streams, so the input stalls
    task automatic test_backpressure();
        write_thick(lcs_pkg::THICK_RESET);
        tx_burst = 1'b1;
        -> rx_hold_go;
        repeat (80) send_query(random_query());
        tx_burst = 1'b0;
        wait_results_done();
    endtask

    task automatic test_random_stream();
        for (int blk = 0; blk < 4; blk++) begin
            write_thick(lcs_pkg::cnt_t'($urandom_range(1, 64)));
            for (int i = 0; i < 150; i++) begin
                // switch between idling and back-to-back stretches
                if (i % 40 == 0) begin
                    tx_burst = ($urandom_range(0, 2) == 0);
                    rx_burst <= ($urandom_range(0, 2) == 0);
                end
                send_query(random_query());
            end
            tx_burst = 1'b0;
            wait_results_done();
        end
    endtask

    // Receiver: random stall per word, plus the long hold-off when asked
    initial begin : result_sink
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            stall = rx_burst ? 0 : $urandom_range(0, 9);
            if (stall > 0 || hold_off) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
                while (hold_off) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Count out the long receiver hold-off
    initial begin : hold_counter
        forever begin
            @(rx_hold_go);
            hold_off <= 1'b1;
            repeat (RX_HOLD_CYCLES) @(posedge aclk);
            hold_off <= 1'b0;
        end
    end

    // Compare each accepted result with the oldest expected span
    always @(posedge aclk) begin : check_results
        span_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.draw     = m_tuser;
            got.row_low  = m_tdata[0 +: ROWB];
            got.row_high = m_tdata[ROWB +: ROWB];
            got.red      = m_tdata[2 * ROWB +: COLB];
            got.green    = m_tdata[2 * ROWB + COLB +: COLB];
            got.blue     = m_tdata[2 * ROWB + 2 * COLB +: COLB];
            if (span_queue.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                want = span_queue.pop_front();
                if (got.draw !== want.draw)
                    report_mismatch($sformatf("draw %b, want %b", got.draw, want.draw));
                if (got.row_low !== want.row_low)
                    report_mismatch($sformatf("row_low %0d, want %0d",
                                              got.row_low, want.row_low));
                if (got.row_high !== want.row_high)
                    report_mismatch($sformatf("row_high %0d, want %0d",
                                              got.row_high, want.row_high));
                if (got.red !== want.red)
                    report_mismatch($sformatf("red %0d, want %0d", got.red, want.red));
                if (got.green !== want.green)
                    report_mismatch($sformatf("green %0d, want %0d", got.green, want.green));
                if (got.blue !== want.blue)
                    report_mismatch($sformatf("blue %0d, want %0d", got.blue, want.blue));
            end
            results_seen++;
        end
    end

    // End the run when no word moves on any channel for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_cases();
        test_thick_sweep();
        test_backpressure();
        test_random_stream();
        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && span_queue.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
